// ===== src/x11rd_pkg.sv =====
`default_nettype none
package x11rd_pkg;

  localparam int NEED_W  = 18;
  localparam int LIMIT_W = 18;

  localparam logic [7:0]         SETUP_MARK  = 8'h42;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'd4096;

  localparam int SETUP_HEADER    = 12;
  localparam int REQ_HEADER      = 4;
  localparam int SETUP_ORDER_POS = 0;
  localparam int SETUP_FIELD_A   = 6;
  localparam int SETUP_FIELD_B   = 8;
  localparam int REQ_FIELD       = 2;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              message_last;
    logic              in_setup_message;
    logic              order_big;
    logic              suspicious_flush;
    logic [NEED_W-1:0] bytes_needed;
  } out_item_t;

endpackage
`default_nettype wire

// ===== src/x11rd_queue.sv =====
`default_nettype none
module x11rd_queue #(
  parameter int WIDTH = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/x11rd_framer.sv =====
`default_nettype none
module x11rd_framer #(
  parameter int COUNT_WIDTH = 18
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [x11rd_pkg::LIMIT_W-1:0]   cfg_value,
  input  wire logic                            in_valid,
  input  wire x11rd_pkg::in_item_t             in_item,
  output logic                                 in_take,
  input  wire logic                            out_full,
  output logic                                 out_push,
  output x11rd_pkg::out_item_t                 out_item
);
  import x11rd_pkg::*;

  localparam int CW = COUNT_WIDTH;

  logic [LIMIT_W-1:0] setup_flush_limit;
  logic               setup_phase;
  logic               order_flag;
  logic [CW-1:0]      position_count;
  logic [CW-1:0]      target_length;
  logic [7:0]         captured_field;
  logic               flush_active;

  logic               fire;
  logic [7:0]         b;
  logic               order_next;
  logic [15:0]        joined;
  logic [16:0]        rounded;
  logic [17:0]        req_len;
  logic [CW-1:0]      target_next;
  logic               flush_next;
  logic               capture;
  logic [CW:0]        pos_plus;
  logic [CW:0]        remain;
  logic [NEED_W-1:0]  tail_need;
  logic               header_part;
  logic [NEED_W-1:0]  need;
  logic               last;

  assign fire     = in_valid && !out_full;
  assign in_take  = fire;
  assign out_push = fire;
  assign b        = in_item.stream_byte;

  always_comb begin
    order_next = order_flag;
    if (setup_phase && position_count == CW'(SETUP_ORDER_POS)) begin
      order_next = (b == SETUP_MARK);
    end
    joined  = order_flag ? {captured_field, b} : {b, captured_field};
    rounded = ({1'b0, joined} + 17'd3) & ~17'd3;
    req_len = (joined == 16'd0) ? 18'(REQ_HEADER) : {joined, 2'b00};

    target_next = target_length;
    capture     = 1'b0;
    if (setup_phase) begin
      if (position_count == CW'(SETUP_FIELD_A) || position_count == CW'(SETUP_FIELD_B)) begin
        capture = 1'b1;
      end
      if (position_count == CW'(SETUP_FIELD_A + 1)) begin
        target_next = CW'(SETUP_HEADER) + CW'(rounded);
      end else if (position_count == CW'(SETUP_FIELD_B + 1)) begin
        target_next = target_length + CW'(rounded);
      end
    end else begin
      if (position_count == CW'(REQ_FIELD)) begin
        capture = 1'b1;
      end
      if (position_count == CW'(REQ_FIELD + 1)) begin
        target_next = CW'(req_len);
      end
    end

    flush_next = flush_active;
    if (setup_phase && position_count == CW'(SETUP_HEADER - 1)
        && target_next > CW'(setup_flush_limit)) begin
      flush_next = 1'b1;
    end

    pos_plus  = {1'b0, position_count} + (CW+1)'(1);
    remain    = {1'b0, target_next} - pos_plus;
    tail_need = ({1'b0, target_next} > pos_plus) ? NEED_W'(remain) : '0;

    if (setup_phase) begin
      header_part = position_count < CW'(SETUP_HEADER - 1);
    end else begin
      header_part = position_count < CW'(REQ_HEADER - 1);
    end

    priority if (setup_phase && flush_next) begin
      need = '0;
      last = in_item.chunk_end;
    end else if (header_part && setup_phase) begin
      need = NEED_W'(SETUP_HEADER - 1) - NEED_W'(position_count);
      last = 1'b0;
    end else if (header_part) begin
      need = NEED_W'(REQ_HEADER - 1) - NEED_W'(position_count);
      last = 1'b0;
    end else begin
      need = tail_need;
      last = (tail_need == '0);
    end

    out_item.out_byte         = b;
    out_item.message_last     = last;
    out_item.in_setup_message = setup_phase;
    out_item.order_big        = order_next;
    out_item.suspicious_flush = setup_phase && flush_next;
    out_item.bytes_needed     = need;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_flush_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      setup_flush_limit <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_phase    <= 1'b1;
      order_flag     <= 1'b0;
      position_count <= '0;
      target_length  <= '0;
      captured_field <= '0;
      flush_active   <= 1'b0;
    end else if (fire) begin
      order_flag <= order_next;
      if (capture) begin
        captured_field <= b;
      end
      if (last) begin
        setup_phase    <= 1'b0;
        flush_active   <= 1'b0;
        position_count <= '0;
        target_length  <= '0;
      end else begin
        flush_active  <= flush_next;
        target_length <= target_next;
        if (position_count != '1) begin
          position_count <= position_count + CW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/x11_request_deframer.sv =====
// Client request deframer.
// Input queue: drive in_item and raise push while full is low; each accepted
// transaction carries one stream byte and its chunk_end flag.
// Result queue: while empty is low, out_item holds the oldest result; raise
// pop to take it. Exactly one result per input byte, in order.
// Configuration: cfg_valid/cfg_ready write setup_flush_limit from cfg_data;
// cfg_ready is always high. Write only while the block is idle.
// Path: a byte accepted into the input queue passes through the combinational
// framer into the result queue, from which out_item is read.
// Throughput: one byte per cycle while the result queue is not full, as the
// framer updates position, length and flush state for every byte it takes.
// Reset (rst, synchronous): both queues empty, setup message pending,
// little-endian order, limit back to 4096.
// Receiver stall: the result queue holds two results; once it fills the
// framer stops, the input queue fills and full rises. No result is lost.
`default_nettype none
module x11_request_deframer #(
  parameter int COUNT_WIDTH = 18
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [x11rd_pkg::LIMIT_W-1:0] cfg_data,
  input  wire logic                          push,
  input  wire x11rd_pkg::in_item_t           in_item,
  output logic                               full,
  input  wire logic                          pop,
  output x11rd_pkg::out_item_t               out_item,
  output logic                               empty
);
  import x11rd_pkg::*;

  in_item_t  head_item;
  logic      in_empty;
  logic      in_take;
  out_item_t framed;
  logic      framed_push;
  logic      out_full;

  assign cfg_ready = 1'b1;

  x11rd_queue #(.WIDTH($bits(in_item_t))) u_in_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_item),
    .full  (full),
    .pop   (in_take),
    .rdata (head_item),
    .empty (in_empty)
  );

  x11rd_framer #(.COUNT_WIDTH(COUNT_WIDTH)) u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .in_valid  (!in_empty),
    .in_item   (head_item),
    .in_take   (in_take),
    .out_full  (out_full),
    .out_push  (framed_push),
    .out_item  (framed)
  );

  x11rd_queue #(.WIDTH($bits(out_item_t))) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (framed_push),
    .wdata (framed),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

endmodule
`default_nettype wire

// ===== dv/deframer_checker.sv =====
module deframer_checker #(
  parameter int COUNT_WIDTH = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [x11rd_pkg::LIMIT_W-1:0] cfg_data,
  input  logic                          push,
  input  logic                          full,
  input  x11rd_pkg::in_item_t           in_item,
  input  logic                          pop,
  input  logic                          empty,
  input  x11rd_pkg::out_item_t          out_item,
  output int                            pending,
  output int                            fail_count
);
  import x11rd_pkg::*;

  localparam longint unsigned POS_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

  out_item_t          echo_q[$];
  logic [LIMIT_W-1:0] flush_limit;
  logic               in_setup;
  logic               big;
  logic               flushing;
  logic [7:0]         held;
  longint unsigned    pos;
  longint unsigned    msg_len;
  int                 errors = 0;
  int                 n_results = 0;

  assign fail_count = errors;

  function automatic longint unsigned join_pair(logic [7:0] first, logic [7:0] second);
    return big ? {first, second} : {second, first};
  endfunction

  function automatic longint unsigned up4(longint unsigned v);
    return (v + 64'd3) & ~64'd3;
  endfunction

  function automatic out_item_t frame_byte(in_item_t it);
    out_item_t       r;
    longint unsigned p;
    longint unsigned need;
    logic            fin;
    logic            was;
    p    = pos;
    need = 0;
    fin  = 1'b0;
    was  = in_setup;
    if (in_setup) begin
      if (p == SETUP_ORDER_POS) big = (it.stream_byte == SETUP_MARK);
      if (p == SETUP_FIELD_A || p == SETUP_FIELD_B) held = it.stream_byte;
      if (p == SETUP_FIELD_A + 1)
        msg_len = SETUP_HEADER + up4(join_pair(held, it.stream_byte));
      if (p == SETUP_FIELD_B + 1)
        msg_len = msg_len + up4(join_pair(held, it.stream_byte));
      if (p == SETUP_HEADER - 1 && msg_len > flush_limit) flushing = 1'b1;
      if (flushing) begin
        fin = it.chunk_end;
      end else if (p < SETUP_HEADER - 1) begin
        need = SETUP_HEADER - 1 - p;
      end else begin
        need = (msg_len > p + 1) ? msg_len - (p + 1) : 0;
        fin  = (need == 0);
      end
    end else begin
      if (p == REQ_FIELD) held = it.stream_byte;
      if (p == REQ_FIELD + 1) begin
        msg_len = join_pair(held, it.stream_byte) << 2;
        if (msg_len < REQ_HEADER) msg_len = REQ_HEADER;
      end
      if (p < REQ_HEADER - 1) begin
        need = REQ_HEADER - 1 - p;
      end else begin
        need = (msg_len > p + 1) ? msg_len - (p + 1) : 0;
        fin  = (need == 0);
      end
    end
    r.out_byte         = it.stream_byte;
    r.message_last     = fin;
    r.in_setup_message = was;
    r.order_big        = big;
    r.suspicious_flush = was & flushing;
    r.bytes_needed     = need[NEED_W-1:0];
    if (fin) begin
      in_setup = 1'b0;
      flushing = 1'b0;
      pos      = 0;
      msg_len  = 0;
    end else if (pos < POS_MAX) begin
      pos = pos + 1;
    end
    return r;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] %s: got %0d, expected %0d (result %0d)", $time, what, got, want,
             n_results);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      flush_limit = LIMIT_RESET;
      in_setup    = 1'b1;
      big         = 1'b0;
      flushing    = 1'b0;
      held        = '0;
      pos         = 0;
      msg_len     = 0;
      echo_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) flush_limit = cfg_data;
      if (push && !full) echo_q.push_back(frame_byte(in_item));
      if (pop && !empty) begin
        if (echo_q.size() == 0) begin
          report("result with no transaction pending", out_item.out_byte, 0);
        end else begin
          want = echo_q.pop_front();
          if (out_item.out_byte !== want.out_byte)
            report("out_byte", out_item.out_byte, want.out_byte);
          if (out_item.message_last !== want.message_last)
            report("message_last", out_item.message_last, want.message_last);
          if (out_item.in_setup_message !== want.in_setup_message)
            report("in_setup_message", out_item.in_setup_message, want.in_setup_message);
          if (out_item.order_big !== want.order_big)
            report("order_big", out_item.order_big, want.order_big);
          if (out_item.suspicious_flush !== want.suspicious_flush)
            report("suspicious_flush", out_item.suspicious_flush, want.suspicious_flush);
          if (out_item.bytes_needed !== want.bytes_needed)
            report("bytes_needed", out_item.bytes_needed, want.bytes_needed);
        end
        n_results++;
      end
    end
    pending <= echo_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import x11rd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;
  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  in_item_t           in_item;
  out_item_t          out_item;
  int                 pending;
  int                 fail_count;
  int                 cycles = 0;
  int                 sent = 0;
  int                 idle_odds = 0;
  int                 stall = 0;
  logic               big = 1'b0;

  x11_request_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .pop       (pop),
    .out_item  (out_item),
    .empty     (empty)
  );

  deframer_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .pop        (pop),
    .empty      (empty),
    .out_item   (out_item),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("x11_request_deframer test failed");
      $finish;
    end
  end

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall = $urandom_range(0, 18);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic c);
    int gap;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      push <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(posedge clk);
    end
    in_item.stream_byte <= b;
    in_item.chunk_end   <= c;
    push                <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_setup(logic [7:0] order_byte, int fa, int fb, logic flush);
    logic [7:0] hdr[12];
    logic       c;
    int         extra;
    foreach (hdr[i]) hdr[i] = 8'($urandom);
    hdr[0] = order_byte;
    if (big) begin
      {hdr[6], hdr[7]} = 16'(fa);
      {hdr[8], hdr[9]} = 16'(fb);
    end else begin
      {hdr[7], hdr[6]} = 16'(fa);
      {hdr[9], hdr[8]} = 16'(fb);
    end
    for (int i = 0; i < 11; i++) send_byte(hdr[i], 1'($urandom_range(0, 1)));
    c = 1'($urandom_range(0, 1));
    send_byte(hdr[11], c);
    if (flush) begin
      while (!c) begin
        c = ($urandom_range(0, 4) == 0);
        send_byte(8'($urandom), c);
      end
    end else begin
      extra = ((fa + 3) & ~3) + ((fb + 3) & ~3);
      repeat (extra) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  // cap truncates the request; zero sends it whole
  task automatic send_request(logic [15:0] len, int cap);
    logic [7:0] b;
    int         total;
    total = (len == 0) ? REQ_HEADER : int'(len) * 4;
    if (cap != 0 && total > cap) total = cap;
    for (int n = 0; n < total; n++) begin
      unique case (n)
        REQ_FIELD:     b = big ? len[15:8] : len[7:0];
        REQ_FIELD + 1: b = big ? len[7:0] : len[15:8];
        default:       b = 8'($urandom);
      endcase
      send_byte(b, $urandom_range(0, 3) == 0);
    end
  endtask

  function automatic logic [15:0] pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($urandom_range(1, 6));
    if (r < 8) return 16'($urandom_range(7, 40));
    return 16'($urandom_range(0, 3));
  endfunction

  initial begin
    int                 mode;
    int                 fa;
    int                 fb;
    int                 lim;
    int                 goal;
    logic [7:0]         order_byte;
    logic               flush;
    logic [LIMIT_W-1:0] phase_limit[4];
    int                 phase_odds[4];
    rst       <= 1'b1;
    push      <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    in_item   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    mode = $urandom_range(0, 3);
    unique case (mode)
      0: begin
        lim = 0;
        fa  = $urandom_range(0, 65535);
        fb  = $urandom_range(0, 65535);
      end
      1: begin
        lim = SETUP_HEADER;
        if ($urandom_range(0, 1)) begin
          fa = 0;
          fb = 0;
        end else begin
          fa = $urandom_range(1, 30);
          fb = $urandom_range(0, 30);
        end
      end
      2: begin
        lim = LIMIT_RESET;
        if ($urandom_range(0, 1)) begin
          fa = $urandom_range(4085, 65535);
          fb = $urandom_range(0, 65535);
        end else begin
          fa = $urandom_range(0, 30);
          fb = $urandom_range(0, 30);
        end
      end
      default: begin
        lim = (1 << LIMIT_W) - 1;
        fa  = $urandom_range(0, 40);
        fb  = $urandom_range(0, 40);
      end
    endcase
    write_limit(LIMIT_W'(lim));
    order_byte = $urandom_range(0, 1) ? SETUP_MARK : 8'($urandom_range(0, 255));
    big        = (order_byte == SETUP_MARK);
    flush      = (SETUP_HEADER + ((fa + 3) & ~3) + ((fb + 3) & ~3)) > lim;
    idle_odds  = 4;
    send_setup(order_byte, fa, fb, flush);
    send_request(16'h0000, 0);
    send_request(16'h0001, 0);
    send_request(16'h0002, 0);

    phase_limit = '{'1, '0, LIMIT_W'(SETUP_HEADER), LIMIT_W'($urandom)};
    phase_odds  = '{3, 12, 0, 6};
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_limit(phase_limit[ph]);
      idle_odds = phase_odds[ph];
      goal      = sent + 330;
      while (sent < goal) send_request(pick_len(), 0);
    end

    idle_odds = 0;
    goal      = sent + 120;
    while (sent < goal) send_request(pick_len(), 0);
    send_request($urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(32768, 65535)), 24);

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("x11_request_deframer test passed");
    end else begin
      $display("x11_request_deframer test failed");
    end
    $finish;
  end

endmodule
